>>> hw/rtl/mqf_pkg.sv
// Shared types and constants for the multi-queue FIFO manager.
// Used by every module of the block except mqf_fifo; depends on nothing.
package mqf_pkg;

  // Defaults of the top-level parameters.
  localparam int NUM_QUEUES_DEF = 4;
  localparam int MAX_DEPTH_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the register file and of the transaction fields.
  localparam int EN_W       = 4;
  localparam int NUM_CAP    = 4;
  localparam int CAP_W      = 7;
  localparam int QID_W      = 3;
  localparam int IO_DATA_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CAP_W-1:0] DEFAULT_CAP = CAP_W'(32);

  // Depths of the internal queues.
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  // Request types.
  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP3   = 3'd4;

  // Control part of a command handed from the front end to the back end.
  typedef struct packed {
    logic                wr;
    logic                rd;
    logic [STATUS_W-1:0] status;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

  // A capacity register of zero selects the default capacity.
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    return (c == '0) ? DEFAULT_CAP : c;
  endfunction

endpackage

>>> hw/rtl/mqf_fifo.sv
// Small register-based FIFO, used for the command queue and the result queue.
// Depends on nothing outside this file.
module mqf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/mqf_front.sv
// Front end: register file, per-queue pointers and counters, request classification.
// Depends on mqf_pkg; issues one command per accepted transaction.
module mqf_front import mqf_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ADDR_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  in_req_type,
  input  logic [QID_W-1:0]      in_queue_id,
  input  logic [IO_DATA_W-1:0]  in_put_data,
  output cmd_ctl_t              cmd_ctl,
  output logic [ADDR_W-1:0]     cmd_addr,
  output logic [DATA_WIDTH-1:0] cmd_data
);

  // Only queues that have an enable bit can ever be created.
  localparam int NQ  = (NUM_QUEUES < EN_W) ? NUM_QUEUES : EN_W;
  localparam int QW  = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int NQE = 2 ** QW;
  localparam int AW  = $clog2(MAX_DEPTH);
  localparam int IW  = ((AW > CAP_W) ? AW : CAP_W) + 1;

  logic [EN_W-1:0]  enable_r, enable_nxt;
  logic [CAP_W-1:0] cap_cfg_r [NUM_CAP];
  logic [CAP_W-1:0] cap_cfg_nxt [NUM_CAP];
  logic [NQE-1:0]   live_r, live_nxt;
  logic [CAP_W-1:0] cap_live_r [NQE];
  logic [CAP_W-1:0] cap_live_nxt [NQE];
  logic [AW-1:0]    head_r [NQE];
  logic [AW-1:0]    head_nxt [NQE];
  logic [AW-1:0]    tail_r [NQE];
  logic [AW-1:0]    tail_nxt [NQE];
  logic [CAP_W-1:0] fill_r [NQE];
  logic [CAP_W-1:0] fill_nxt [NQE];

  logic [QW-1:0]    qidx;
  logic             q_ok;
  logic             is_full, is_empty;
  logic [AW-1:0]    idx_sel;
  logic [31:0]      addr_full;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i,
                                             input logic [CAP_W-1:0] c);
    logic [IW-1:0] n;
    n = IW'(i) + IW'(1);
    return (n == IW'(c)) ? '0 : n[AW-1:0];
  endfunction

  assign qidx     = in_queue_id[QW-1:0];
  assign q_ok     = (in_queue_id < QID_W'(NQ)) && live_r[qidx];
  assign is_full  = (fill_r[qidx] >= cap_live_r[qidx]);
  assign is_empty = (fill_r[qidx] == '0);
  assign idx_sel  = (in_req_type == REQ_PUT) ? tail_r[qidx] : head_r[qidx];

  // Queue q owns the words starting at q times the maximum depth.
  assign addr_full = 32'(qidx) * 32'(MAX_DEPTH) + 32'(idx_sel);
  assign cmd_addr  = addr_full[ADDR_W-1:0];
  assign cmd_data  = DATA_WIDTH'(in_put_data);

  always_comb begin
    cmd_ctl.wr     = 1'b0;
    cmd_ctl.rd     = 1'b0;
    cmd_ctl.status = ST_OK;
    if (!q_ok) begin
      cmd_ctl.status = ST_INVALID;
    end else if (in_req_type == REQ_PUT) begin
      if (is_full) begin
        cmd_ctl.status = ST_FULL;
      end else begin
        cmd_ctl.wr = 1'b1;
      end
    end else begin
      if (is_empty) begin
        cmd_ctl.status = ST_EMPTY;
      end else begin
        cmd_ctl.rd = 1'b1;
      end
    end
  end

  always_comb begin
    enable_nxt   = enable_r;
    cap_cfg_nxt  = cap_cfg_r;
    live_nxt     = live_r;
    cap_live_nxt = cap_live_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: begin
          enable_nxt = cfg_data[EN_W-1:0];
          for (int q = 0; q < NQE; q++) begin
            if (q < NQ) begin
              if (cfg_data[q] && !enable_r[q]) begin
                // Creation samples the capacity and empties the queue.
                head_nxt[q] = '0;
                tail_nxt[q] = '0;
                fill_nxt[q] = '0;
                if (32'(eff_cap(cap_cfg_r[q])) <= 32'(MAX_DEPTH)) begin
                  live_nxt[q]     = 1'b1;
                  cap_live_nxt[q] = eff_cap(cap_cfg_r[q]);
                end else begin
                  live_nxt[q]     = 1'b0;
                  cap_live_nxt[q] = '0;
                end
              end else if (!cfg_data[q] && enable_r[q]) begin
                live_nxt[q] = 1'b0;
              end
            end
          end
        end
        CFG_CAP0: cap_cfg_nxt[0] = cfg_data[CAP_W-1:0];
        CFG_CAP1: cap_cfg_nxt[1] = cfg_data[CAP_W-1:0];
        CFG_CAP2: cap_cfg_nxt[2] = cfg_data[CAP_W-1:0];
        CFG_CAP3: cap_cfg_nxt[3] = cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      if (cmd_ctl.wr) begin
        tail_nxt[qidx] = ring_inc(tail_r[qidx], cap_live_r[qidx]);
        fill_nxt[qidx] = fill_r[qidx] + CAP_W'(1);
      end else if (cmd_ctl.rd) begin
        head_nxt[qidx] = ring_inc(head_r[qidx], cap_live_r[qidx]);
        fill_nxt[qidx] = fill_r[qidx] - CAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      live_r   <= '0;
      for (int i = 0; i < NUM_CAP; i++) begin
        cap_cfg_r[i] <= '0;
      end
      for (int q = 0; q < NQE; q++) begin
        cap_live_r[q] <= '0;
        head_r[q]     <= '0;
        tail_r[q]     <= '0;
        fill_r[q]     <= '0;
      end
    end else begin
      enable_r   <= enable_nxt;
      live_r     <= live_nxt;
      cap_cfg_r  <= cap_cfg_nxt;
      cap_live_r <= cap_live_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      fill_r     <= fill_nxt;
    end
  end

endmodule

>>> hw/rtl/mqf_back.sv
// Back end: shared word store, registered read and the result queue.
// Depends on mqf_pkg and mqf_fifo.
module mqf_back import mqf_pkg::*; #(
  parameter int ADDR_W     = 8,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MEM_DEPTH  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_ctl_t              cmd_ctl,
  input  logic [ADDR_W-1:0]     cmd_addr,
  input  logic [DATA_WIDTH-1:0] cmd_data,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IO_DATA_W-1:0]  out_get_data
);

  localparam int OCW   = $clog2(OUTQ_DEPTH+1);
  localparam int RES_W = STATUS_W + IO_DATA_W;

  logic [DATA_WIDTH-1:0] store_r [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  stage_v_r, stage_v_nxt;
  logic                  stage_rd_r;
  logic [STATUS_W-1:0]   stage_status_r;
  logic [OCW-1:0]        oq_count;
  logic                  room;
  logic [RES_W-1:0]      res_word, oq_rdata;
  logic [IO_DATA_W-1:0]  res_data;

  // A command is issued only when the result queue can take it, counting the
  // transaction that is still in the read stage.
  assign room        = ({1'b0, oq_count} + (OCW+1)'(stage_v_r)) < (OCW+1)'(OUTQ_DEPTH);
  assign cmd_pop     = !cmd_empty && room;
  assign stage_v_nxt = cmd_pop;

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_ctl.wr) begin
      store_r[cmd_addr] <= cmd_data;
    end
    if (cmd_pop && cmd_ctl.rd) begin
      rdata_r <= store_r[cmd_addr];
    end
    if (cmd_pop) begin
      stage_rd_r     <= cmd_ctl.rd;
      stage_status_r <= cmd_ctl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  assign res_data = stage_rd_r ? IO_DATA_W'(rdata_r) : '0;
  assign res_word = {stage_status_r, res_data};

  mqf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (stage_v_r),
    .wdata (res_word),
    .full  (),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .count (oq_count)
  );

  assign out_status   = oq_rdata[RES_W-1 -: STATUS_W];
  assign out_get_data = oq_rdata[IO_DATA_W-1:0];

endmodule

>>> hw/rtl/multi_queue_fifo_manager.sv
// Multi-queue FIFO manager: several ring-buffer queues sharing one word store.
// Throughput: one transaction per cycle while results drain; the back end has one store port.
// Path: an accepted transaction passes the command queue, the store read register and the
// result queue before its result is poppable; results that are not drained hold it back.
// Reset (synchronous, rst_n low) clears registers, queue state and internal queues;
// the word store is not cleared and needs no clearing pass.
module multi_queue_fifo_manager import mqf_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_req_type,
  input  logic [QID_W-1:0]      in_queue_id,
  input  logic [IO_DATA_W-1:0]  in_put_data,
  output logic                  empty,
  input  logic                  pop,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IO_DATA_W-1:0]  out_get_data
);

  localparam int NQ        = (NUM_QUEUES < EN_W) ? NUM_QUEUES : EN_W;
  localparam int MEM_DEPTH = NQ * MAX_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CMD_W     = CTL_W + ADDR_W + DATA_WIDTH;

  logic                  accept;
  cmd_ctl_t              f_ctl, b_ctl;
  logic [ADDR_W-1:0]     f_addr, b_addr;
  logic [DATA_WIDTH-1:0] f_data, b_data;
  logic                  cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0]      cmd_rdata;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  mqf_front #(
    .NUM_QUEUES (NUM_QUEUES),
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .in_req_type (in_req_type),
    .in_queue_id (in_queue_id),
    .in_put_data (in_put_data),
    .cmd_ctl     (f_ctl),
    .cmd_addr    (f_addr),
    .cmd_data    (f_data)
  );

  mqf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata ({f_ctl, f_addr, f_data}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .count ()
  );

  assign {b_ctl, b_addr, b_data} = cmd_rdata;

  mqf_back #(
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ctl      (b_ctl),
    .cmd_addr     (b_addr),
    .cmd_data     (b_data),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .out_pop      (pop),
    .out_empty    (empty),
    .out_status   (out_status),
    .out_get_data (out_get_data)
  );

`ifndef SYNTH
  // A command that touches the store must carry a good status.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (f_ctl.wr || f_ctl.rd) |-> f_ctl.status == ST_OK)
    else $error("store access issued with an error status");

  // A command never both writes and reads the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !(b_ctl.wr && b_ctl.rd))
    else $error("command both writes and reads the store");

  // Leaving reset, both internal queues start empty.
  assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> empty && cmd_empty)
    else $error("queues not empty after reset");

  // A transaction accepted into an empty command queue is visible to the back end next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd_empty |=> !cmd_empty)
    else $error("accepted transaction lost in the command queue");
`endif

endmodule
